/* hdl/rrm_pkg.sv */
// Package for the radial ramp mask pixel unit.
// Holds word types, register codes and shared constants; depends on nothing.
package rrm_pkg;

  localparam int COORD_W = 12;
  localparam int RADIUS_W = COORD_W + 1;
  localparam int VALUE_W = 8;
  localparam int FRACTION_BITS_DEF = 4;

  localparam logic [VALUE_W-1:0] FULL_SCALE = 8'd255;

  localparam logic [COORD_W-1:0] CENTER_X_RST = 12'd320;
  localparam logic [COORD_W-1:0] CENTER_Y_RST = 12'd240;
  localparam logic [RADIUS_W-1:0] INNER_RADIUS_RST = 13'd250;
  localparam logic [RADIUS_W-1:0] OUTER_RADIUS_RST = 13'd350;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_INNER_RADIUS = 2'd2,
    CFG_OUTER_RADIUS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mask_value;
    logic [VALUE_W-1:0] inverted_value;
  } mask_t;

  // Ramp side band: force selects a fixed value, full picks 255 over 0.
  typedef struct packed {
    logic force_val;
    logic full;
  } div_ctl_t;

endpackage

/* hdl/rrm_dist_sq.sv */
// Front end of the ramp unit: distance to the centre, squared and scaled.
// Three register stages; uses rrm_pkg.
module rrm_dist_sq #(
  parameter int FRACTION_BITS = rrm_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        up_valid,
  input  rrm_pkg::pixel_t             up_pixel,
  input  logic [rrm_pkg::COORD_W-1:0] center_x,
  input  logic [rrm_pkg::COORD_W-1:0] center_y,
  output logic                        valid,
  output logic [2*(rrm_pkg::COORD_W+1+FRACTION_BITS)-1:0] rad
);

  localparam int CW = rrm_pkg::COORD_W;
  localparam int RAD_W = 2 * (CW + 1 + FRACTION_BITS);

  logic          a_valid;
  logic [CW-1:0] dx;
  logic [CW-1:0] dy;
  logic          b_valid;
  logic [2*CW-1:0] sqx;
  logic [2*CW-1:0] sqy;
  logic [2*CW:0]   sum;

  assign sum = {1'b0, sqx} + {1'b0, sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      a_valid <= up_valid;
      b_valid <= a_valid;
      valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= (up_pixel.pixel_x >= center_x) ? up_pixel.pixel_x - center_x
                                           : center_x - up_pixel.pixel_x;
      dy <= (up_pixel.pixel_y >= center_y) ? up_pixel.pixel_y - center_y
                                           : center_y - up_pixel.pixel_y;
      sqx <= dx * dx;
      sqy <= dy * dy;
      rad <= RAD_W'(sum) << (2 * FRACTION_BITS);
    end
  end

endmodule

/* hdl/rrm_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per cycle while en is high.
// Restoring digit-by-digit method; uses no package items.
module rrm_sqrt_cell #(
  parameter int ROOT_W = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  up_valid,
  input  logic [2*ROOT_W-1:0]   up_rad,
  input  logic [ROOT_W+1:0]     up_rem,
  input  logic [ROOT_W-1:0]     up_root,
  output logic                  valid,
  output logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W+1:0]     rem,
  output logic [ROOT_W-1:0]     root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int WIDE_W = ROOT_W + 4;

  logic [WIDE_W-1:0] rem_sh;
  logic [WIDE_W-1:0] trial;
  logic [WIDE_W-1:0] diff;
  logic              ge;

  // Bring down the next two radicand bits and try root*4+1.
  assign rem_sh = {up_rem, up_rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, up_root, 2'b01};
  assign ge = rem_sh >= trial;
  assign diff = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {up_root[ROOT_W-2:0], ge};
      rad <= {up_rad[RAD_W-3:0], 2'b00};
    end
  end

endmodule

/* hdl/rrm_div_cell.sv */
// One cell of the ramp divider chain: settles one quotient bit per cycle while en is high.
// Dividend bits shift out of lq as quotient bits shift in; uses rrm_pkg.
module rrm_div_cell #(
  parameter int DEN_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        up_valid,
  input  rrm_pkg::div_ctl_t           up_ctl,
  input  logic [DEN_W-1:0]            up_rem,
  input  logic [rrm_pkg::VALUE_W-1:0] up_lq,
  input  logic [DEN_W-1:0]            den,
  output logic                        valid,
  output rrm_pkg::div_ctl_t           ctl,
  output logic [DEN_W-1:0]            rem,
  output logic [rrm_pkg::VALUE_W-1:0] lq
);

  localparam int VW = rrm_pkg::VALUE_W;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] diff;
  logic           ge;

  assign rem_sh = {up_rem, up_lq[VW-1]};
  assign ge = rem_sh >= {1'b0, den};
  assign diff = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= up_ctl;
      rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      lq <= {up_lq[VW-2:0], ge};
    end
  end

endmodule

/* hdl/radial_ramp_mask_pixel_unit.sv */
// Top level of the radial ramp mask pixel unit: registers, chains, output skid.
// Depends on rrm_pkg, rrm_dist_sq, rrm_sqrt_cell and rrm_div_cell.
//
// Channel   Signals                              Direction  Word
// pixel     pixel_valid, pixel_stall, pixel      in         pixel_x, pixel_y
// mask      mask_valid, mask_stall, mask         out        mask_value, inverted_value
// cfg       cfg_valid, cfg_ready, cfg_index/data in         register write
//
// One pixel word enters per cycle while pixel_stall is low; each result passes the distance
// stages, the one-bit-per-cell root chain, the setup registers, the divider chain and the output register.
// Reset (rst, synchronous) empties the pipeline and loads the default centre and radii.
// A stalled result is caught in a one-word skid register; pixel_stall is that
// register's full flag, so the whole chain holds only while two results wait.
module radial_ramp_mask_pixel_unit #(
  parameter int FRACTION_BITS = rrm_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  rrm_pkg::pixel_t              pixel,
  output logic                         mask_valid,
  input  logic                         mask_stall,
  output rrm_pkg::mask_t               mask,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [rrm_pkg::RADIUS_W-1:0] cfg_data
);

  localparam int CW = rrm_pkg::COORD_W;
  localparam int RDW = rrm_pkg::RADIUS_W;
  localparam int VW = rrm_pkg::VALUE_W;
  localparam int RW = CW + 1 + FRACTION_BITS;
  localparam int DW = RDW + FRACTION_BITS;
  localparam int NW = DW + VW;

  logic [CW-1:0]  center_x;
  logic [CW-1:0]  center_y;
  logic [RDW-1:0] inner_radius;
  logic [RDW-1:0] outer_radius;

  logic en;
  logic skid_full;
  logic out_take;
  rrm_pkg::mask_t skid;
  rrm_pkg::mask_t result;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= rrm_pkg::CENTER_X_RST;
      center_y <= rrm_pkg::CENTER_Y_RST;
      inner_radius <= rrm_pkg::INNER_RADIUS_RST;
      outer_radius <= rrm_pkg::OUTER_RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rrm_pkg::cfg_reg_e'(cfg_index))
        rrm_pkg::CFG_CENTER_X:     center_x <= cfg_data[CW-1:0];
        rrm_pkg::CFG_CENTER_Y:     center_y <= cfg_data[CW-1:0];
        rrm_pkg::CFG_INNER_RADIUS: inner_radius <= cfg_data;
        rrm_pkg::CFG_OUTER_RADIUS: outer_radius <= cfg_data;
      endcase
    end
  end

  assign en = !skid_full;
  assign pixel_stall = skid_full;

  // Squared distance.
  logic [RW:0]     sq_valid;
  logic [2*RW-1:0] sq_rad [RW+1];
  logic [RW+1:0]   sq_rem [RW+1];
  logic [RW-1:0]   sq_root [RW+1];

  rrm_dist_sq #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dist (
    .clk(clk),
    .rst(rst),
    .en(en),
    .up_valid(pixel_valid),
    .up_pixel(pixel),
    .center_x(center_x),
    .center_y(center_y),
    .valid(sq_valid[0]),
    .rad(sq_rad[0])
  );

  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rrm_sqrt_cell #(
      .ROOT_W(RW)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .up_valid(sq_valid[i]),
      .up_rad(sq_rad[i]),
      .up_rem(sq_rem[i]),
      .up_root(sq_root[i]),
      .valid(sq_valid[i+1]),
      .rad(sq_rad[i+1]),
      .rem(sq_rem[i+1]),
      .root(sq_root[i+1])
    );
  end

  // Ramp setup: both radius compares run on the distance directly.
  logic [DW-1:0] distance;
  logic [DW-1:0] lo;
  logic [DW-1:0] hi;
  logic [DW-1:0] den;
  logic          degen;
  logic          ge_lo;
  logic          ge_hi;

  assign distance = DW'(sq_root[RW]);
  assign lo = DW'(inner_radius) << FRACTION_BITS;
  assign hi = DW'(outer_radius) << FRACTION_BITS;
  assign den = DW'(outer_radius - inner_radius) << FRACTION_BITS;
  assign degen = outer_radius <= inner_radius;
  assign ge_lo = distance >= lo;
  assign ge_hi = distance >= hi;

  logic              s1_valid;
  rrm_pkg::div_ctl_t s1_ctl;
  logic [DW-1:0]     s1_num;
  logic [VW:0]       dv_valid;
  rrm_pkg::div_ctl_t dv_ctl [VW+1];
  logic [DW-1:0]     dv_rem [VW+1];
  logic [VW-1:0]     dv_lq [VW+1];
  logic [NW-1:0]     s2_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      s1_valid <= sq_valid[RW];
      dv_valid[0] <= s1_valid;
    end
  end

  // The dividend 255*num is num*256 - num.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl.force_val <= degen || !ge_lo || ge_hi;
      s1_ctl.full <= ge_lo && (degen || ge_hi);
      s1_num <= distance - lo;
      dv_ctl[0] <= s1_ctl;
      s2_n <= {s1_num, {VW{1'b0}}} - NW'(s1_num);
    end
  end

  assign dv_rem[0] = s2_n[NW-1:VW];
  assign dv_lq[0] = s2_n[VW-1:0];

  for (genvar j = 0; j < VW; j++) begin : g_div
    rrm_div_cell #(
      .DEN_W(DW)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .up_valid(dv_valid[j]),
      .up_ctl(dv_ctl[j]),
      .up_rem(dv_rem[j]),
      .up_lq(dv_lq[j]),
      .den(den),
      .valid(dv_valid[j+1]),
      .ctl(dv_ctl[j+1]),
      .rem(dv_rem[j+1]),
      .lq(dv_lq[j+1])
    );
  end

  always_comb begin
    if (dv_ctl[VW].force_val) begin
      result.mask_value = dv_ctl[VW].full ? rrm_pkg::FULL_SCALE : '0;
    end else begin
      result.mask_value = dv_lq[VW];
    end
    result.inverted_value = rrm_pkg::FULL_SCALE - result.mask_value;
  end

  // Output register with a one-word skid behind it.
  assign out_take = !mask_valid || !mask_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_take) begin
      mask_valid <= skid_full || dv_valid[VW];
      skid_full <= 1'b0;
    end else if (en && dv_valid[VW]) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      mask <= skid_full ? skid : result;
    end else if (en) begin
      skid <= result;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_full |-> mask_valid)
    else $error("skid holds a word while the output register is empty");

  assert property (@(posedge clk) disable iff (rst)
    (skid_full && mask_stall) |=> skid_full)
    else $error("skid word dropped while the output was stalled");

  assert property (@(posedge clk) disable iff (rst) !mask_valid |=> !skid_full)
    else $error("skid filled although the output register was free");

endmodule
